/* rtl/fcab_pkg.sv */
// ----------------------------------------------------------------------------
// fcab_pkg
// Shared types and constants of the flood counter with automatic blocklist.
// ----------------------------------------------------------------------------
package fcab_pkg;

  // default table sizes
  localparam int unsigned FLOOD_ENTRIES_DEF = 16;
  localparam int unsigned BLOCK_ENTRIES_DEF = 64;

  // field widths
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned STAT_W  = 2;

  // threshold after reset and saturation value of a count
  localparam logic [COUNT_W-1:0] THRESH_RST = 8'd2;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'd255;

  // item modes
  localparam logic [MODE_W-1:0] MODE_CHECK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REPORT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FLOOD_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BLOCK_FULL = 2'd2;

  // contents written into one flood table slot
  typedef struct packed {
    logic               active;
    logic [ADDR_W-1:0]  address;
    logic [COUNT_W-1:0] count;
  } fld_wr_t;

endpackage

/* rtl/fcab_flood_table.sv */
// ----------------------------------------------------------------------------
// fcab_flood_table
// Flood slots: active bits, addresses and counts, one slot read per cycle.
// ----------------------------------------------------------------------------
module fcab_flood_table
  import fcab_pkg::*;
#(
  parameter int unsigned ENTRIES = FLOOD_ENTRIES_DEF,
  parameter int unsigned IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [IW-1:0] rd_idx,
  output fld_wr_t       rd_slot,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_idx,
  input  fld_wr_t       wr_slot
);

  logic               active_r [ENTRIES];
  logic [ADDR_W-1:0]  addr_r   [ENTRIES];
  logic [COUNT_W-1:0] cnt_r    [ENTRIES];

  // active bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        active_r[i] <= 1'b0;
      end
    end else if (wr_en) begin
      active_r[wr_idx] <= wr_slot.active;
    end
  end

  // slot payload, only meaningful while active
  always_ff @(posedge clk) begin
    if (wr_en) begin
      addr_r[wr_idx] <= wr_slot.address;
      cnt_r[wr_idx]  <= wr_slot.count;
    end
  end

  // read of the slot under scan
  assign rd_slot.active  = active_r[rd_idx];
  assign rd_slot.address = addr_r[rd_idx];
  assign rd_slot.count   = cnt_r[rd_idx];

endmodule

/* rtl/fcab_block_mem.sv */
// ----------------------------------------------------------------------------
// fcab_block_mem
// Blocklist store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fcab_block_mem
  import fcab_pkg::*;
#(
  parameter int unsigned DEPTH = BLOCK_ENTRIES_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [ADDR_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [ADDR_W-1:0] rd_data
);

  logic [ADDR_W-1:0] mem_r [DEPTH];
  logic [ADDR_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/flood_counter_auto_blacklist_top.sv */
// ----------------------------------------------------------------------------
// flood_counter_auto_blacklist_top
// Flood attempt counter with an append-only blocklist, one comparator shared.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per item, tdata = mode, address.
//   out_* : one transaction per item, tdata = blocked, attempt_count,
//           promoted, status.
//   cfg_* : write of flood_threshold, only while the block is idle.
// Timing: one item at a time, in_tready is high only while the sequencer
//   is idle. A single 32-bit comparator serves every search. Steps from
//   the accepted item until the result is in the output register:
//   - check:  blocklist memory read one entry a cycle, compare in the
//             cycle after each read, stops on the first match
//   - report: flood slot scan one slot a cycle, an update state, then
//             the result state loads the output register once it is free
//   - clear:  flood slot scan one slot a cycle, stops on the first match
//   - append: an append state, then the result state
//   The next item is accepted in the cycle after the result is loaded, at the earliest.
// Reset clears all flood slots, empties the blocklist and sets the
//   threshold to 2. A stalled receiver holds the result in the output
//   register; the next item is taken meanwhile and its result waits.
// ----------------------------------------------------------------------------
module flood_counter_auto_blacklist_top
  import fcab_pkg::*;
#(
  parameter int unsigned FLOOD_ENTRIES = FLOOD_ENTRIES_DEF,
  parameter int unsigned BLOCK_ENTRIES = BLOCK_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // mode [1:0], address [33:2], zero fill above
  input  logic [39:0]  in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // blocked [0], attempt_count [8:1], promoted [9], status [11:10]
  output logic [15:0]  out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_wr_en,
  input  logic [7:0]   cfg_wr_data
);

  localparam int unsigned FIW = (FLOOD_ENTRIES > 1) ? $clog2(FLOOD_ENTRIES) : 1;
  localparam int unsigned BIW = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
  localparam int unsigned BSW = $clog2(BLOCK_ENTRIES + 1);
  localparam logic [FIW-1:0] FLD_LAST = FIW'(FLOOD_ENTRIES - 1);
  localparam logic [BSW-1:0] BLK_CAP  = BSW'(BLOCK_ENTRIES);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BLK  = 3'd1;
  localparam logic [2:0] S_FLD  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_APP  = 3'd4;
  localparam logic [2:0] S_RESP = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [COUNT_W-1:0]  thresh_r;
  logic [BSW-1:0]      size_r, size_nxt;
  logic [BSW-1:0]      rd_idx_r, rd_idx_nxt;
  logic                pend_r, pend_nxt;
  logic [FIW-1:0]      scan_r, scan_nxt;
  logic                free_ok_r, free_ok_nxt;
  logic [FIW-1:0]      free_r, free_nxt;
  logic [FIW-1:0]      slot_r, slot_nxt;
  logic [COUNT_W-1:0]  base_r, base_nxt;
  logic                res_blk_r, res_blk_nxt;
  logic [COUNT_W-1:0]  res_cnt_r, res_cnt_nxt;
  logic                res_pro_r, res_pro_nxt;
  logic [STAT_W-1:0]   res_st_r, res_st_nxt;
  logic                out_vld_r, out_vld_nxt;
  logic [15:0]         out_data_r, out_data_nxt;

  fld_wr_t             fld_rd;
  fld_wr_t             fld_wr;
  logic                fld_we;
  logic [FIW-1:0]      fld_widx;
  logic                mem_we;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_rd;
  logic [ADDR_W-1:0]   cmp_a;
  logic                cmp_eq;
  logic                room;
  logic [COUNT_W-1:0]  inc_cnt;
  logic                in_acc;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign room      = (size_r < BLK_CAP);

  // shared address comparator
  assign cmp_a  = (state_r == S_BLK) ? mem_rd : fld_rd.address;
  assign cmp_eq = (cmp_a == addr_r);

  // saturating increment of the slot count
  assign inc_cnt = (base_r == COUNT_MAX) ? COUNT_MAX : base_r + COUNT_W'(1);

  fcab_flood_table #(
    .ENTRIES (FLOOD_ENTRIES),
    .IW      (FIW)
  ) u_flood_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (scan_r),
    .rd_slot (fld_rd),
    .wr_en   (fld_we),
    .wr_idx  (fld_widx),
    .wr_slot (fld_wr)
  );

  fcab_block_mem #(
    .DEPTH   (BLOCK_ENTRIES),
    .AW      (BIW)
  ) u_block_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (size_r[BIW-1:0]),
    .wr_data (addr_r),
    .rd_en   (mem_re),
    .rd_addr (rd_idx_r[BIW-1:0]),
    .rd_data (mem_rd)
  );

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    addr_nxt     = addr_r;
    size_nxt     = size_r;
    rd_idx_nxt   = rd_idx_r;
    pend_nxt     = pend_r;
    scan_nxt     = scan_r;
    free_ok_nxt  = free_ok_r;
    free_nxt     = free_r;
    slot_nxt     = slot_r;
    base_nxt     = base_r;
    res_blk_nxt  = res_blk_r;
    res_cnt_nxt  = res_cnt_r;
    res_pro_nxt  = res_pro_r;
    res_st_nxt   = res_st_r;
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    fld_we       = 1'b0;
    fld_widx     = slot_r;
    fld_wr       = '0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;

    // output register drains independently
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mode_nxt    = in_tdata[1:0];
          addr_nxt    = in_tdata[33:2];
          rd_idx_nxt  = '0;
          pend_nxt    = 1'b0;
          scan_nxt    = '0;
          free_ok_nxt = 1'b0;
          res_blk_nxt = 1'b0;
          res_cnt_nxt = '0;
          res_pro_nxt = 1'b0;
          res_st_nxt  = STAT_OK;
          case (in_tdata[1:0])
            MODE_CHECK:  state_nxt = S_BLK;
            MODE_APPEND: state_nxt = S_APP;
            default:     state_nxt = S_FLD;
          endcase
        end
      end

      // blocklist search, compare in the cycle after the read
      S_BLK: begin
        if (pend_r && cmp_eq) begin
          res_blk_nxt = 1'b1;
          state_nxt   = S_RESP;
        end else if (rd_idx_r == size_r && !pend_r) begin
          state_nxt = S_RESP;
        end else if (rd_idx_r < size_r) begin
          mem_re     = 1'b1;
          rd_idx_nxt = rd_idx_r + BSW'(1);
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
      end

      // flood slot scan, noting the first free slot
      S_FLD: begin
        if (fld_rd.active && cmp_eq) begin
          if (mode_r == MODE_CLEAR) begin
            fld_we    = 1'b1;
            fld_widx  = scan_r;
            fld_wr    = '0;
            state_nxt = S_RESP;
          end else begin
            slot_nxt  = scan_r;
            base_nxt  = fld_rd.count;
            state_nxt = S_UPD;
          end
        end else begin
          if (!fld_rd.active && !free_ok_r) begin
            free_ok_nxt = 1'b1;
            free_nxt    = scan_r;
          end
          if (scan_r == FLD_LAST) begin
            if (mode_r == MODE_CLEAR) begin
              state_nxt = S_RESP;
            end else if (free_ok_r || !fld_rd.active) begin
              slot_nxt  = free_ok_r ? free_r : scan_r;
              base_nxt  = '0;
              state_nxt = S_UPD;
            end else begin
              res_st_nxt = STAT_FLOOD_FULL;
              state_nxt  = S_RESP;
            end
          end else begin
            scan_nxt = scan_r + FIW'(1);
          end
        end
      end

      // count update and possible promotion
      S_UPD: begin
        fld_we   = 1'b1;
        fld_widx = slot_r;
        if (inc_cnt >= thresh_r && room) begin
          mem_we      = 1'b1;
          size_nxt    = size_r + BSW'(1);
          fld_wr      = '0;
          res_pro_nxt = 1'b1;
        end else begin
          fld_wr.active  = 1'b1;
          fld_wr.address = addr_r;
          fld_wr.count   = inc_cnt;
          res_cnt_nxt    = inc_cnt;
          if (inc_cnt >= thresh_r) begin
            res_st_nxt = STAT_BLOCK_FULL;
          end
        end
        state_nxt = S_RESP;
      end

      // direct append
      S_APP: begin
        if (room) begin
          mem_we      = 1'b1;
          size_nxt    = size_r + BSW'(1);
          res_pro_nxt = 1'b1;
        end else begin
          res_st_nxt = STAT_BLOCK_FULL;
        end
        state_nxt = S_RESP;
      end

      // hand the result to the output register once it is free
      S_RESP: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = {4'd0, res_st_r, res_pro_r, res_cnt_r, res_blk_r};
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      size_r    <= '0;
      out_vld_r <= 1'b0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      size_r    <= size_nxt;
      out_vld_r <= out_vld_nxt;
      pend_r    <= pend_nxt;
    end
  end

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RST;
    end else if (cfg_wr_en) begin
      thresh_r <= cfg_wr_data;
    end
  end

  // item and working registers
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    addr_r     <= addr_nxt;
    rd_idx_r   <= rd_idx_nxt;
    scan_r     <= scan_nxt;
    free_ok_r  <= free_ok_nxt;
    free_r     <= free_nxt;
    slot_r     <= slot_nxt;
    base_r     <= base_nxt;
    res_blk_r  <= res_blk_nxt;
    res_cnt_r  <= res_cnt_nxt;
    res_pro_r  <= res_pro_nxt;
    res_st_r   <= res_st_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

/* tb/sv/fcab_monitor.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fcab_monitor
// Watches the item, result and threshold ports of the flood counter, keeps a
// private copy of the flood table and blocklist, works out the result of each
// accepted item and compares every returned result against it in order.
// ----------------------------------------------------------------------------
module fcab_monitor
  import fcab_pkg::*;
#(
  parameter int unsigned FLOOD_N = FLOOD_ENTRIES_DEF,
  parameter int unsigned BLOCK_N = BLOCK_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // mode [1:0], address [33:2], zero fill above
  input  logic [39:0]       in_tdata,
  input  logic              in_tvalid,
  input  logic              in_tready,
  // blocked [0], attempt_count [8:1], promoted [9], status [11:10]
  input  logic [15:0]       out_tdata,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  output int unsigned       exp_left,
  output int unsigned       mismatches
);

  // one result, laid out as in the low bits of out_tdata
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic               promoted;
    logic [COUNT_W-1:0] attempts;
    logic               blocked;
  } verdict_t;

  // shadow of the block state
  logic [ADDR_W-1:0]  fl_addr [FLOOD_N];
  logic               fl_act  [FLOOD_N];
  logic [COUNT_W-1:0] fl_cnt  [FLOOD_N];
  logic [ADDR_W-1:0]  blk_addr [BLOCK_N];
  int unsigned        blk_fill;
  logic [COUNT_W-1:0] thresh;

  verdict_t    pending_verdicts [$];
  int unsigned verdict_errs;

  function automatic void free_slot(input int s);
    fl_act[s]  = 1'b0;
    fl_cnt[s]  = '0;
    fl_addr[s] = '0;
  endfunction

  // expected result of one item, updating the shadow state on the way
  function automatic verdict_t predict_verdict(input logic [MODE_W-1:0] mode,
                                               input logic [ADDR_W-1:0] addr);
    verdict_t v;
    int       slot;
    v    = '0;
    slot = -1;
    // lowest active slot holding the address
    for (int i = FLOOD_N - 1; i >= 0; i--)
      if (fl_act[i] && fl_addr[i] == addr) slot = i;
    case (mode)
      MODE_CHECK: begin
        for (int i = 0; i < blk_fill; i++)
          if (blk_addr[i] == addr) v.blocked = 1'b1;
      end
      MODE_REPORT: begin
        // unknown address takes the first free slot
        if (slot < 0) begin
          for (int i = FLOOD_N - 1; i >= 0; i--)
            if (!fl_act[i]) slot = i;
          if (slot >= 0) begin
            fl_act[slot]  = 1'b1;
            fl_addr[slot] = addr;
            fl_cnt[slot]  = '0;
          end
        end
        if (slot < 0) begin
          v.status = STAT_FLOOD_FULL;
        end else begin
          if (fl_cnt[slot] != COUNT_MAX) fl_cnt[slot] = fl_cnt[slot] + 1'b1;
          v.attempts = fl_cnt[slot];
          // promote when the threshold is met and the blocklist has room
          if (fl_cnt[slot] >= thresh) begin
            if (blk_fill < BLOCK_N) begin
              blk_addr[blk_fill] = addr;
              blk_fill++;
              free_slot(slot);
              v.promoted = 1'b1;
              v.attempts = '0;
            end else begin
              v.status = STAT_BLOCK_FULL;
            end
          end
        end
      end
      MODE_CLEAR: begin
        if (slot >= 0) free_slot(slot);
      end
      default: begin
        if (blk_fill < BLOCK_N) begin
          blk_addr[blk_fill] = addr;
          blk_fill++;
          v.promoted = 1'b1;
        end else begin
          v.status = STAT_BLOCK_FULL;
        end
      end
    endcase
    return v;
  endfunction

  function automatic void cmp_field(input string fname, input logic [7:0] want,
                                    input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d",
               $time, fname, want, got);
      verdict_errs++;
    end
  endfunction

  // result check first, so a result never meets the expectation pushed
  // by a transaction in the same cycle
  always @(posedge clk) begin
    verdict_t want;
    verdict_t got;
    if (!rst_n) begin
      for (int i = 0; i < FLOOD_N; i++) free_slot(i);
      for (int i = 0; i < BLOCK_N; i++) blk_addr[i] = '0;
      blk_fill = 0;
      thresh   = THRESH_RST;
      pending_verdicts.delete();
      verdict_errs = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[11:0];
        if (pending_verdicts.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual 0x%03h",
                   $time, got);
          verdict_errs++;
        end else begin
          want = pending_verdicts.pop_front();
          cmp_field("blocked", want.blocked, got.blocked);
          cmp_field("attempt_count", want.attempts, got.attempts);
          cmp_field("promoted", want.promoted, got.promoted);
          cmp_field("status", want.status, got.status);
        end
      end
      if (in_tvalid && in_tready)
        pending_verdicts.push_back(predict_verdict(in_tdata[1:0], in_tdata[33:2]));
      if (cfg_wr_en) thresh = cfg_wr_data;
    end
    exp_left   <= pending_verdicts.size();
    mismatches <= verdict_errs;
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the flood counter with automatic blocklist: a directed opening,
// then phases of random items under several thresholds, with random idling on
// both channels, a long receiver hold-off and a full drain between phases.
// ----------------------------------------------------------------------------
module tb;
  import fcab_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int LONG_HOLD   = 400;
  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 100;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  // mode [1:0], address [33:2], zero fill above
  logic [39:0]       in_tdata    = '0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  // blocked [0], attempt_count [8:1], promoted [9], status [11:10]
  logic [15:0]       out_tdata;
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic              cfg_wr_en   = 1'b0;
  logic [7:0]        cfg_wr_data = '0;

  int unsigned       exp_left;
  int unsigned       mismatches;
  int unsigned       quiet_cycles = 0;

  // idling percentage shared by both sides, and long hold-off requests
  int unsigned       gap_pct = 12;
  int unsigned       hold_req = 0;
  int unsigned       hold_done = 0;

  logic [ADDR_W-1:0] pool [32];
  int unsigned       pool_n = 1;
  logic [ADDR_W-1:0] flood_set [17];
  logic [ADDR_W-1:0] hot_addr;

  flood_counter_auto_blacklist_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  fcab_monitor mon (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .exp_left    (exp_left),
    .mismatches  (mismatches)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // result receiver: random stall bursts and the occasional long hold-off
  initial begin
    @(posedge clk);
    forever begin
      if (hold_done != hold_req) begin
        hold_done++;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // offer one item and wait for its transaction, then maybe idle
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] addr);
    in_tdata  <= {6'b0, addr, mode};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // stop offering until every expected result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (exp_left != 0);
  endtask

  task automatic write_threshold(input logic [7:0] value);
    drain();
    repeat (4) @(posedge clk);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic new_pool(input int unsigned n);
    pool_n = n;
    for (int i = 0; i < n; i++) pool[i] = $urandom();
    pool[0] = $urandom_range(0, 1) ? '1 : '0;
  endtask

  function automatic logic [ADDR_W-1:0] pick_addr();
    if ($urandom_range(0, 9) < 7) return pool[$urandom_range(0, pool_n - 1)];
    return $urandom();
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode(input int unsigned app_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < app_pct) return MODE_APPEND;
    if (r < app_pct + 25) return MODE_CHECK;
    if (r < app_pct + 40) return MODE_CLEAR;
    return MODE_REPORT;
  endfunction

  task automatic run_mix(input int unsigned n, input int unsigned app_pct);
    for (int k = 0; k < n; k++) send_item(pick_mode(app_pct), pick_addr());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening at the reset threshold of two
    send_item(MODE_CHECK,  32'h0000_0000);
    send_item(MODE_CHECK,  32'hFFFF_FFFF);
    send_item(MODE_REPORT, 32'hFFFF_FFFF);
    send_item(MODE_REPORT, 32'hFFFF_FFFF);
    send_item(MODE_CHECK,  32'hFFFF_FFFF);
    send_item(MODE_REPORT, 32'h0000_0000);
    send_item(MODE_CLEAR,  32'h0000_0000);
    // clear of an address that holds no slot
    send_item(MODE_CLEAR,  32'h1234_5678);
    send_item(MODE_REPORT, 32'h0000_0000);
    // direct append twice, giving a duplicate entry
    send_item(MODE_APPEND, 32'hA5A5_A5A5);
    send_item(MODE_APPEND, 32'hA5A5_A5A5);
    send_item(MODE_CHECK,  32'hA5A5_A5A5);
    send_item(MODE_CHECK,  32'h5A5A_5A5A);
    send_item(MODE_CLEAR,  32'h0000_0000);

    // threshold of zero promotes on the first report
    write_threshold(8'd0);
    send_item(MODE_REPORT, 32'h8000_0001);
    send_item(MODE_CHECK,  32'h8000_0001);

    // fill the flood table, then a report with no slot left
    write_threshold(8'd255);
    for (int i = 0; i < 17; i++) flood_set[i] = $urandom();
    for (int i = 0; i < 16; i++) send_item(MODE_REPORT, flood_set[i]);
    send_item(MODE_REPORT, flood_set[16]);
    send_item(MODE_REPORT, flood_set[5]);
    send_item(MODE_CLEAR,  flood_set[5]);
    send_item(MODE_REPORT, flood_set[16]);
    for (int i = 0; i < 17; i++) send_item(MODE_CLEAR, flood_set[i]);

    // random phases while the blocklist still has room
    new_pool(12);
    write_threshold(8'd0);
    run_mix(20, 5);
    new_pool(20);
    write_threshold(8'($urandom_range(3, 8)));
    run_mix(300, 3);
    // a stretch with no idling at a threshold of one
    gap_pct = 0;
    new_pool(12);
    write_threshold(8'd1);
    run_mix(150, 3);
    gap_pct = 12;

    // make sure the blocklist is full, appends beyond that are refused
    for (int k = 0; k < 64; k++) send_item(MODE_APPEND, pick_addr());

    // one address driven to saturation with some noise between
    write_threshold(8'd255);
    hot_addr = $urandom();
    for (int k = 0; k < 270; k++) begin
      if ($urandom_range(0, 9) == 0) send_item(pick_mode(10), $urandom());
      send_item(MODE_REPORT, hot_addr);
    end
    send_item(MODE_CLEAR, hot_addr);

    // wide thresholds, a long receiver hold-off and a mid-phase drain
    new_pool(24);
    write_threshold(8'($urandom_range(2, 200)));
    run_mix(250, 5);
    hold_req++;
    run_mix(150, 5);
    drain();
    run_mix(200, 5);

    // closing part with no idling
    new_pool(10);
    write_threshold(8'($urandom_range(1, 10)));
    gap_pct = 0;
    run_mix(300, 5);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && exp_left == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
